>>> design/pot_pkg.sv
package pot_pkg;

    localparam int WORD_CAPACITY = 32;
    localparam int STORE_DEPTH   = 32;
    localparam int MAX_EXPONENT  = 616;

    // Cells in the row: capacity limited to the storage depth, never below one.
    localparam int CAP = (WORD_CAPACITY > STORE_DEPTH) ? STORE_DEPTH :
                         ((WORD_CAPACITY < 1) ? 1 : WORD_CAPACITY);

    localparam int WORD_W  = 64;
    localparam int CARRY_W = 4;
    localparam int EXP_W   = 11;
    localparam int STEP_W  = 10;
    localparam int IDX_W   = 5;
    localparam int CNT_W   = 6;
    localparam int STAT_W  = 2;

    localparam logic [STAT_W-1:0] ST_OK  = 2'd0;
    localparam logic [STAT_W-1:0] ST_NEG = 2'd1;
    localparam logic [STAT_W-1:0] ST_OVF = 2'd2;

    // Carry wavefront handed from one cell to the next.
    typedef struct packed {
        logic               act;
        logic [CARRY_W-1:0] carry;
    } t_link;

endpackage

>>> design/pot_cell.sv
module pot_cell
    import pot_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  logic              i_init,
    input  logic              i_shift,
    input  t_link             i_link,
    input  logic [WORD_W-1:0] i_next_word,
    input  logic              i_next_used,
    output t_link             o_link,
    output logic [WORD_W-1:0] o_word,
    output logic              o_used
);

    logic [WORD_W-1:0]         r_word;
    logic [CARRY_W-1:0]        r_carry;
    logic                      r_act;
    logic                      r_used;
    logic [WORD_W+CARRY_W-1:0] prod;

    // word * 10 + carry_in as (word << 3) + (word << 1) + carry_in
    always_comb begin
        prod = {1'b0, r_word, 3'b000} + {3'b000, r_word, 1'b0}
             + {{WORD_W{1'b0}}, i_link.carry};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act  <= 1'b0;
            r_used <= 1'b0;
        end else if (i_load) begin
            r_act  <= 1'b0;
            r_used <= i_init;
        end else if (i_shift) begin
            r_act  <= 1'b0;
            r_used <= i_next_used;
        end else begin
            r_act  <= i_link.act;
            // a nonzero carry into an empty word appends it
            if (i_link.act && (i_link.carry != '0)) begin
                r_used <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_word  <= WORD_W'(i_init);
            r_carry <= '0;
        end else if (i_shift) begin
            r_word  <= i_next_word;
        end else if (i_link.act) begin
            r_word  <= prod[WORD_W-1:0];
            r_carry <= prod[WORD_W+CARRY_W-1:WORD_W];
        end
    end

    assign o_link.act   = r_act;
    assign o_link.carry = r_carry;
    assign o_word       = r_word;
    assign o_used       = r_used;

endmodule

>>> design/pot_chain.sv
module pot_chain
    import pot_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  logic              i_shift,
    input  logic              i_feed_act,
    output t_link             o_top_link,
    output logic [WORD_W-1:0] o_word0,
    output logic              o_used0,
    output logic [CNT_W-1:0]  o_count
);

    t_link             link   [CAP+1];
    logic [WORD_W-1:0] words  [CAP+1];
    logic [CAP:0]      used;

    assign link[0].act   = i_feed_act;
    assign link[0].carry = '0;
    assign words[CAP]    = '0;
    assign used[CAP]     = 1'b0;

    for (genvar g = 0; g < CAP; g++) begin : g_cell
        pot_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_load      (i_load),
            .i_init      ((g == 0) ? 1'b1 : 1'b0),
            .i_shift     (i_shift),
            .i_link      (link[g]),
            .i_next_word (words[g+1]),
            .i_next_used (used[g+1]),
            .o_link      (link[g+1]),
            .o_word      (words[g]),
            .o_used      (used[g])
        );
    end

    // used flags form a run from cell 0; length is the highest set flag + 1
    always_comb begin
        o_count = '0;
        for (int i = 0; i < CAP; i++) begin
            if (used[i]) begin
                o_count = CNT_W'(i + 1);
            end
        end
    end

    assign o_top_link = link[CAP];
    assign o_word0    = words[0];
    assign o_used0    = used[0];

    a_thermometer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (used[CAP-1:0] & (used[CAP-1:0] + CAP'(1))) == '0)
        else $error("used flags not contiguous from cell 0");

    a_top_carry_only_when_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(used[CAP-1]) && !$past(i_load) && !$past(i_shift) |-> $past(link[CAP-1].act))
        else $error("top word appended without an active carry");

endmodule

>>> design/power_of_ten_multiword_top.sv
// An error beat is valid in the cycle after the exponent is accepted.
// A valid exponent k gives its first word once k multiply steps have entered cell 0,
//   the carry wave has crossed the row and the word count has been taken.
// Throughput: one word per cycle while the sink is ready; one request at a time,
//   so a new exponent is taken only after the last word or error beat is accepted.
// Reset: synchronous active-low i_rst_n clears the controller and cell flags only.
module power_of_ten_multiword_top
    import pot_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic signed [EXP_W-1:0] i_exponent,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic [STAT_W-1:0]       o_status,
    output logic [WORD_W-1:0]       o_word_value,
    output logic [IDX_W-1:0]        o_word_index,
    output logic [CNT_W-1:0]        o_word_count,
    output logic                    o_last_word
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RUN,
        S_COUNT,
        S_EMIT,
        S_ERR
    } t_state;

    t_state              r_state,  n_state;
    logic [STEP_W-1:0]   r_steps,  n_steps;   // multiply steps still to feed
    logic [CNT_W-1:0]    r_drain,  n_drain;   // cycles for the wave to cross the row
    logic                r_ovf,    n_ovf;     // carry fell off the top cell
    logic [STAT_W-1:0]   r_status, n_status;
    logic [IDX_W-1:0]    r_idx,    n_idx;
    logic [CNT_W-1:0]    r_count,  n_count;

    logic              load;
    logic              shift;
    logic              feed_act;
    t_link             top_link;
    logic [WORD_W-1:0] word0;
    logic              used0;
    logic [CNT_W-1:0]  chain_count;
    logic              is_last;

    pot_chain u_chain (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (load),
        .i_shift    (shift),
        .i_feed_act (feed_act),
        .o_top_link (top_link),
        .o_word0    (word0),
        .o_used0    (used0),
        .o_count    (chain_count)
    );

    assign is_last = ((CNT_W'(r_idx) + CNT_W'(1)) == r_count);

    always_comb begin
        n_state  = r_state;
        n_steps  = r_steps;
        n_drain  = r_drain;
        n_ovf    = r_ovf;
        n_status = r_status;
        n_idx    = r_idx;
        n_count  = r_count;
        load     = 1'b0;
        shift    = 1'b0;
        feed_act = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_exponent[EXP_W-1]) begin
                        // negative exponent: report and leave the cells alone
                        n_status = ST_NEG;
                        n_state  = S_ERR;
                    end else if (i_exponent[STEP_W-1:0] > STEP_W'(MAX_EXPONENT)) begin
                        n_status = ST_OVF;
                        n_state  = S_ERR;
                    end else begin
                        // restart from the single word 1
                        load    = 1'b1;
                        n_steps = i_exponent[STEP_W-1:0];
                        n_drain = CNT_W'(CAP);
                        n_ovf   = 1'b0;
                        n_state = S_RUN;
                    end
                end
            end
            S_RUN: begin
                if (top_link.act && (top_link.carry != '0)) begin
                    n_ovf = 1'b1;
                end
                if (r_steps != '0) begin
                    // launch one multiply-by-ten wave into cell 0
                    feed_act = 1'b1;
                    n_steps  = r_steps - STEP_W'(1);
                end else if (r_drain != '0) begin
                    n_drain = r_drain - CNT_W'(1);
                end else begin
                    n_state = S_COUNT;
                end
            end
            S_COUNT: begin
                n_count = chain_count;
                if (r_ovf) begin
                    n_status = ST_OVF;
                    n_state  = S_ERR;
                end else begin
                    n_status = ST_OK;
                    n_idx    = '0;
                    n_state  = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_out_ready) begin
                    if (is_last) begin
                        n_state = S_IDLE;
                    end else begin
                        // advance the next word into cell 0
                        shift = 1'b1;
                        n_idx = r_idx + IDX_W'(1);
                    end
                end
            end
            S_ERR: begin
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_steps  <= '0;
            r_drain  <= '0;
            r_ovf    <= 1'b0;
            r_status <= ST_OK;
            r_idx    <= '0;
            r_count  <= '0;
        end else begin
            r_state  <= n_state;
            r_steps  <= n_steps;
            r_drain  <= n_drain;
            r_ovf    <= n_ovf;
            r_status <= n_status;
            r_idx    <= n_idx;
            r_count  <= n_count;
        end
    end

    // Output beat: the word always sits in cell 0; errors carry zero payload.
    assign o_in_ready   = (r_state == S_IDLE);
    assign o_out_valid  = (r_state == S_EMIT) || (r_state == S_ERR);
    assign o_status     = (r_state == S_EMIT) ? ST_OK : r_status;
    assign o_word_value = (r_state == S_EMIT) ? word0 : '0;
    assign o_word_index = (r_state == S_EMIT) ? r_idx : '0;
    assign o_word_count = (r_state == S_EMIT) ? r_count : '0;
    assign o_last_word  = (r_state == S_EMIT) ? is_last : (r_state == S_ERR);

    a_emit_word_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> used0 && (r_count != '0))
        else $error("emitting a word that was never built");

    a_error_single_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != ST_OK) |-> o_last_word && (o_word_count == '0))
        else $error("error beat not a single last beat");

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !o_out_valid)
        else $error("new request taken while a result is pending");

    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (CNT_W'(r_idx) < r_count))
        else $error("word index past word count");

endmodule

>>> tb/sv/tb_power_of_ten_multiword_top.sv
module tb_power_of_ten_multiword_top
    import pot_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD   = 8;
    localparam int RESET_CYCLES = 8;
    localparam int RANDOM_ITEMS = 43;      // per idling phase, three phases
    localparam int SINK_HOLD    = 1000;    // longer than the slowest request
    localparam int DRAIN_CYCLES = CAP + 16;
    localparam int MAX_REPORTS  = 10;

    // One output beat: a word of the power of ten, or an error marker.
    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [WORD_W-1:0] value;
        logic [IDX_W-1:0]  index;
        logic [CNT_W-1:0]  count;
        logic              last;
    } t_pow_word;

    // Directed row: the exponent, and where typed is set, the single beat it gives.
    typedef struct packed {
        logic [EXP_W-1:0]  exponent;
        logic              typed;
        logic [STAT_W-1:0] status;
        logic [WORD_W-1:0] value;
        logic [CNT_W-1:0]  count;
    } t_exp_row;

    localparam int N_DIRECTED = 20;

    t_exp_row directed_rows [N_DIRECTED] = '{
        '{11'd0,    1'b1, ST_OK,  64'd1,                  6'd1},  // zero right after reset
        '{11'h7FF,  1'b1, ST_NEG, 64'd0,                  6'd0},  // minus one
        '{11'h400,  1'b1, ST_NEG, 64'd0,                  6'd0},  // most negative exponent
        '{11'd617,  1'b1, ST_OVF, 64'd0,                  6'd0},  // just above the maximum
        '{11'd1023, 1'b1, ST_OVF, 64'd0,                  6'd0},  // largest positive field
        '{11'd1,    1'b1, ST_OK,  64'd10,                 6'd1},
        '{11'd19,   1'b1, ST_OK,  64'h8AC7_2304_89E8_0000, 6'd1},  // largest single word
        '{11'd20,   1'b0, ST_OK,  64'd0,                  6'd0},  // first carry into word 1
        '{11'd616,  1'b0, ST_OK,  64'd0,                  6'd0},  // maximum, fills the row
        '{11'd615,  1'b0, ST_OK,  64'd0,                  6'd0},
        '{11'd2,    1'b0, ST_OK,  64'd0,                  6'd0},
        '{11'd38,   1'b0, ST_OK,  64'd0,                  6'd0},
        '{11'd39,   1'b0, ST_OK,  64'd0,                  6'd0},  // third word appears
        '{11'h600,  1'b1, ST_NEG, 64'd0,                  6'd0},  // minus 512
        '{11'd512,  1'b0, ST_OK,  64'd0,                  6'd0},
        '{11'd1000, 1'b1, ST_OVF, 64'd0,                  6'd0},
        '{11'd0,    1'b1, ST_OK,  64'd1,                  6'd1},  // zero after an overflow
        '{11'd618,  1'b1, ST_OVF, 64'd0,                  6'd0},
        '{11'd100,  1'b0, ST_OK,  64'd0,                  6'd0},
        '{11'd255,  1'b0, ST_OK,  64'd0,                  6'd0}
    };

    logic                    i_clk        = 1'b0;
    logic                    i_rst_n      = 1'b0;
    logic                    i_in_valid   = 1'b0;
    logic                    o_in_ready;
    logic signed [EXP_W-1:0] i_exponent   = '0;
    logic                    o_out_valid;
    logic                    i_out_ready  = 1'b0;
    logic [STAT_W-1:0]       o_status;
    logic [WORD_W-1:0]       o_word_value;
    logic [IDX_W-1:0]        o_word_index;
    logic [CNT_W-1:0]        o_word_count;
    logic                    o_last_word;

    // Words still owed by the block, oldest first.
    t_pow_word expected_words [$];

    // Own copy of the block's scratch words and word count.
    logic [WORD_W-1:0] pow_store [STORE_DEPTH];
    int unsigned       pow_used;

    int  fail_count     = 0;
    int  report_count   = 0;
    int  src_idle_pct   = 31;
    int  sink_idle_pct  = 54;
    bit  hold_request   = 1'b0;
    int  hold_left      = 0;

    power_of_ten_multiword_top uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_exponent   (i_exponent),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_status     (o_status),
        .o_word_value (o_word_value),
        .o_word_index (o_word_index),
        .o_word_count (o_word_count),
        .o_last_word  (o_last_word)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Build ten to the power e word by word and queue the beats it must produce.
    // Errors collapse to one beat with every other field zero and last set.
    function automatic void queue_pow10(input logic [EXP_W-1:0] e);
        int unsigned        k;
        int unsigned        len;
        logic [CARRY_W-1:0] carry;
        logic [67:0]        prod;
        t_pow_word          beat;
        if (e[EXP_W-1]) begin
            expected_words.push_back('{ST_NEG, '0, '0, '0, 1'b1});
            return;
        end
        k = int'(e);
        if (k > MAX_EXPONENT) begin
            expected_words.push_back('{ST_OVF, '0, '0, '0, 1'b1});
            return;
        end
        pow_store[0] = 64'd1;
        len = 1;
        for (int unsigned step = 0; step < k; step++) begin
            carry = '0;
            // Ripple the times-ten through the live words; the carry stays below ten.
            for (int unsigned i = 0; i < len; i++) begin
                prod         = 68'(pow_store[i]) * 68'd10 + 68'(carry);
                pow_store[i] = prod[WORD_W-1:0];
                carry        = prod[67:64];
            end
            if (carry != '0) begin
                // A leftover carry with the row already full is an overflow.
                if (len >= CAP) begin
                    expected_words.push_back('{ST_OVF, '0, '0, '0, 1'b1});
                    return;
                end
                pow_store[len] = 64'(carry);
                len++;
            end
        end
        pow_used = len;
        for (int unsigned i = 0; i < len; i++) begin
            beat.status = ST_OK;
            beat.value  = pow_store[i];
            beat.index  = IDX_W'(i);
            beat.count  = CNT_W'(len);
            beat.last   = (i + 1 == len);
            expected_words.push_back(beat);
        end
    endfunction

    // Draw an exponent: many cheap ones, some near the top, errors of both kinds.
    function automatic logic [EXP_W-1:0] pick_exponent();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 40)      return EXP_W'($urandom_range(40, 0));
        else if (r < 55) return EXP_W'($urandom_range(MAX_EXPONENT, 0));
        else if (r < 65) return EXP_W'($urandom_range(MAX_EXPONENT, MAX_EXPONENT - 16));
        else if (r < 70) return EXP_W'($urandom_range(MAX_EXPONENT + 14, MAX_EXPONENT + 1));
        else if (r < 80) return EXP_W'($urandom_range(1023, MAX_EXPONENT + 1));
        else if (r < 95) return {1'b1, 10'($urandom)};
        else             return EXP_W'($urandom_range(1, 0));
    endfunction

    // Offer one exponent and return in the time step of the edge that accepts it.
    // Idle cycles drop valid first; valid is never lowered and raised in one step.
    task automatic offer_exponent(input logic [EXP_W-1:0] e);
        while ($urandom_range(99) < src_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_exponent <= e;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic report_beat(input string what, input t_pow_word want,
                               input t_pow_word got);
        fail_count++;
        if (report_count < MAX_REPORTS) begin
            report_count++;
            $display("%0t %s: status %0d/%0d value %h/%h index %0d/%0d count %0d/%0d last %0b/%0b",
                     $realtime, what, want.status, got.status, want.value, got.value,
                     want.index, got.index, want.count, got.count, want.last, got.last);
        end
    endtask

    // Compare one accepted output beat against the oldest owed word.
    task automatic check_word();
        t_pow_word got;
        t_pow_word want;
        got = '{o_status, o_word_value, o_word_index, o_word_count, o_last_word};
        if (expected_words.size() == 0) begin
            report_beat("unexpected beat (exp/got)", '0, got);
            return;
        end
        want = expected_words.pop_front();
        if (got.status !== want.status || got.value !== want.value ||
            got.index  !== want.index  || got.count !== want.count ||
            got.last   !== want.last)
            report_beat("word mismatch (exp/got)", want, got);
    endtask

    // Sink side: check the beat taken at this edge, then pick ready for the next.
    // A hold request parks ready low for a long stretch so the block backs up
    // and stalls its input while the source keeps offering.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            check_word();
        if (hold_left > 0) begin
            i_out_ready <= 1'b0;
            hold_left = hold_left - 1;
        end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = SINK_HOLD - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    initial begin
        logic [EXP_W-1:0] e;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed rows: typed rows carry their own beat, the rest go to the predictor.
        foreach (directed_rows[n]) begin
            offer_exponent(directed_rows[n].exponent);
            if (directed_rows[n].typed)
                expected_words.push_back('{directed_rows[n].status, directed_rows[n].value,
                                           '0, directed_rows[n].count, 1'b1});
            else
                queue_pow10(directed_rows[n].exponent);
        end

        // Three idling phases: sink slow, then source slow, then both flat out.
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    src_idle_pct  = 31;
                    sink_idle_pct = 54;
                end
                1: begin
                    src_idle_pct  = 54;
                    sink_idle_pct = 31;
                end
                default: begin
                    src_idle_pct  = 0;
                    sink_idle_pct = 0;
                    hold_request  = 1'b1;
                end
            endcase
            repeat (RANDOM_ITEMS) begin
                e = pick_exponent();
                offer_exponent(e);
                queue_pow10(e);
            end
        end
        i_in_valid <= 1'b0;

        // Drain: wait for every owed word, then watch for stray beats.
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_words.size() != 0)
            fail_count++;

        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #10_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

>>> power_of_ten_multiword_top.f
design/pot_pkg.sv
design/pot_cell.sv
design/pot_chain.sv
design/power_of_ten_multiword_top.sv
tb/sv/tb_power_of_ten_multiword_top.sv
